// ===== hdl/u2lcd_pkg.sv =====
package u2lcd_pkg;

   // Field widths fixed by the character stream format.
   localparam int CODE_W     = 21;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int CSR_INDEX_W = 1;

   // Most result items one input item can cause: the previously held
   // character, the character held back by this item, and the terminator.
   localparam int RES_MAX = 3;

   // Default depth of the result queue; it must hold at least RES_MAX items.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_SURROGATE_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CHARS      = 1'd1;

   localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 8'd80;

   // Code points and ROM bytes with a role of their own.
   localparam logic [CODE_W-1:0] CP_MACRON     = 21'h000304;
   localparam logic [CODE_W-1:0] CP_BACKSLASH  = 21'h00005C;
   localparam logic [CODE_W-1:0] CP_TILDE      = 21'h00007E;
   localparam logic [CODE_W-1:0] CP_HIGH_FIRST = 21'h00D800;
   localparam logic [CODE_W-1:0] CP_HIGH_LAST  = 21'h00DBFF;
   localparam logic [CODE_W-1:0] KANA_OFFSET   = 21'h00FEC0;

   localparam logic [BYTE_W-1:0] ROM_X_BAR   = 8'hF8;
   localparam logic [BYTE_W-1:0] ROM_BLOCK   = 8'hFF;
   localparam logic [BYTE_W-1:0] ROM_YEN     = 8'hA4;
   localparam logic [BYTE_W-1:0] ROM_DASH    = 8'h2D;
   localparam logic [BYTE_W-1:0] ROM_LOWER_X = 8'h78;
   localparam logic [BYTE_W-1:0] ROM_NUL     = 8'h00;

   typedef struct packed {
      logic [BYTE_W-1:0]  char_byte;
      logic               last_byte;
      logic [COUNT_W-1:0] char_count;
   } rsp_type;

   // Maps one code point to its character ROM byte.
   function automatic logic [BYTE_W-1:0] map_code(input logic [CODE_W-1:0] cp);
      logic [BYTE_W-1:0] code;
      logic [CODE_W-1:0] diff;
      diff = cp - KANA_OFFSET;
      code = ROM_BLOCK;
      if (cp >= 21'h20 && cp <= 21'h7E) begin
         if (cp == CP_BACKSLASH) begin
            code = ROM_YEN;
         end else if (cp == CP_TILDE) begin
            code = ROM_DASH;
         end else begin
            code = cp[BYTE_W-1:0];
         end
      end else if (cp >= 21'h00FF61 && cp <= 21'h00FF9F) begin
         code = diff[BYTE_W-1:0];
      end else begin
         case (cp)
            21'h0000A5: code = 8'h5C;
            21'h002192: code = 8'h7E;
            21'h002190: code = 8'h7F;
            21'h0000B0: code = 8'hDF;
            21'h0003B1: code = 8'hE0;
            21'h0000C4, 21'h0000E4: code = 8'hE1;
            21'h0000DF: code = 8'hE2;
            21'h0003B5: code = 8'hE3;
            21'h0000B5, 21'h0003BC: code = 8'hE4;
            21'h0003C2: code = 8'hE5;
            21'h0003C1: code = 8'hE6;
            21'h00221A: code = 8'hE8;
            21'h0000B9: code = 8'hE9;
            21'h0000A4: code = 8'hEB;
            21'h0000A2: code = 8'hEC;
            21'h002C60: code = 8'hED;
            21'h0000F1: code = 8'hEE;
            21'h0000D6, 21'h0000F6: code = 8'hEF;
            21'h0003F4: code = 8'hF2;
            21'h00221E: code = 8'hF3;
            21'h0003A9: code = 8'hF4;
            21'h0000DC, 21'h0000FC: code = 8'hF5;
            21'h0003A3: code = 8'hF6;
            21'h0003C0: code = 8'hF7;
            21'h000304: code = 8'hF8;
            21'h0000F7: code = 8'hFD;
            default:    code = ROM_BLOCK;
         endcase
      end
      return code;
   endfunction

endpackage

// ===== hdl/u2lcd_queue.sv =====
module u2lcd_queue #(
   parameter int DEPTH = u2lcd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  u2lcd_pkg::rsp_type  push_data [u2lcd_pkg::RES_MAX],
   input  logic                pop,
   output u2lcd_pkg::rsp_type  head,
   output logic                not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import u2lcd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int SUM_W = PTR_W + 2;

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_idx [RES_MAX];

   // Pointer plus a small offset, wrapped once at the queue depth.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [1:0] offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(ptr) + SUM_W'(offs);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < RES_MAX; i++) begin
         wr_idx[i] = wrap_add(wr_ptr_ff, 2'(i));
      end
      wr_ptr_in = wrap_add(wr_ptr_ff, push_n);
      rd_ptr_in = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (2'(i) < push_n) begin
            mem_ff[wr_idx[i]] <= push_data[i];
         end
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== hdl/unicode_to_lcd_charset.sv =====
// Converts a stream of Unicode code units into character ROM bytes for an
// HD44780-style LCD with the A00 ROM. Each accepted item is one code unit with
// an end_of_text flag; each result item is one ROM byte with the running
// character count, and a string always closes with a NUL byte flagged by
// last_byte. Printable ASCII passes through (backslash and tilde are swapped
// for their ROM look-alikes), halfwidth katakana is shifted into the ROM's kana
// range, a small set of symbols goes through a lookup, and everything else
// shows as the solid block 0xFF. The most recent character is held back one
// place so a following combining macron can rewrite it, so results lag the
// input by one character until end of text flushes it. Rate: the mapping is
// done in the cycle an item is accepted and its results (zero to three) go
// into a result queue, so one item is accepted every cycle while the queue
// holds no more than QUEUE_DEPTH minus three results. The queue drains one
// result per cycle while rsp_stall is low, so a long run of items that each
// cause one result streams at one item per cycle; a string's closing item can
// cause three results. Configuration (surrogate_mode and max_chars) is
// written through the csr port, which is always ready.
module unicode_to_lcd_charset #(
   parameter int QUEUE_DEPTH = u2lcd_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [u2lcd_pkg::CODE_W-1:0]        req_code_unit,
   input  logic                                req_end_of_text,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [u2lcd_pkg::BYTE_W-1:0]        rsp_char_byte,
   output logic                                rsp_last_byte,
   output logic [u2lcd_pkg::COUNT_W-1:0]       rsp_char_count,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [u2lcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [u2lcd_pkg::COUNT_W-1:0]       csr_data
);
   import u2lcd_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   // Configuration registers.
   logic                 surrogate_mode_ff;
   logic [COUNT_W-1:0]   max_chars_ff;

   // String state. The value of a pending high surrogate never matters,
   // because every supplementary code point maps to the block character, so
   // only its presence is kept.
   logic                 held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0]    held_byte_ff, held_byte_in;
   logic [COUNT_W-1:0]   emitted_ff, emitted_in;
   logic                 high_half_ff, high_half_in;
   logic                 stopped_ff, stopped_in;

   logic                 accept;
   logic                 pop;
   logic [BYTE_W-1:0]    mapped;
   logic                 is_high;
   logic                 room;
   logic                 have;
   logic                 macron;
   logic [BYTE_W-1:0]    code;
   logic [1:0]           n_res;
   rsp_type              res [RES_MAX];
   rsp_type              head;
   logic                 not_empty;
   logic [CNT_W-1:0]     q_count;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // Room for the worst case of three results, independent of this cycle's pop.
   assign req_stall = (q_count > CNT_W'(QUEUE_DEPTH - RES_MAX));

   assign mapped  = map_code(req_code_unit);
   assign is_high = (req_code_unit >= CP_HIGH_FIRST) && (req_code_unit <= CP_HIGH_LAST);
   // A character is taken only while the emitted and held characters leave
   // capacity; the sum is widened so it cannot wrap.
   assign room    = ({1'b0, emitted_ff} + {{COUNT_W{1'b0}}, held_valid_ff})
                    < {1'b0, max_chars_ff};

   always_comb begin
      stopped_in    = stopped_ff;
      high_half_in  = high_half_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      emitted_in    = emitted_ff;
      have          = 1'b0;
      macron        = 1'b0;
      code          = ROM_BLOCK;
      n_res         = 2'd0;
      for (int i = 0; i < RES_MAX; i++) begin
         res[i] = '0;
      end

      if (!stopped_ff) begin
         if (req_code_unit == '0) begin
            stopped_in   = 1'b1;
            high_half_in = 1'b0;
         end else if (high_half_ff) begin
            // The unit after a high surrogate completes one character that is
            // either supplementary or malformed; both show as the block.
            high_half_in = 1'b0;
            have         = 1'b1;
         end else if (surrogate_mode_ff && is_high) begin
            high_half_in = 1'b1;
         end else begin
            have   = 1'b1;
            code   = mapped;
            macron = (req_code_unit == CP_MACRON);
         end

         if (have && room) begin
            if (macron) begin
               // A macron over x becomes x-bar; over anything else, or with
               // nothing held, it leaves the block character.
               if (held_valid_ff) begin
                  held_byte_in = (held_byte_ff == ROM_LOWER_X) ? ROM_X_BAR : ROM_BLOCK;
               end else begin
                  held_byte_in  = ROM_BLOCK;
                  held_valid_in = 1'b1;
               end
            end else begin
               if (held_valid_ff) begin
                  emitted_in            = emitted_ff + 8'd1;
                  res[n_res].char_byte  = held_byte_ff;
                  res[n_res].last_byte  = 1'b0;
                  res[n_res].char_count = emitted_in;
                  n_res                 = n_res + 2'd1;
               end
               held_byte_in  = code;
               held_valid_in = 1'b1;
            end
         end
      end

      if (req_end_of_text) begin
         if (held_valid_in) begin
            emitted_in            = emitted_in + 8'd1;
            res[n_res].char_byte  = held_byte_in;
            res[n_res].last_byte  = 1'b0;
            res[n_res].char_count = emitted_in;
            n_res                 = n_res + 2'd1;
         end
         res[n_res].char_byte  = ROM_NUL;
         res[n_res].last_byte  = 1'b1;
         res[n_res].char_count = emitted_in;
         n_res                 = n_res + 2'd1;
         stopped_in    = 1'b0;
         high_half_in  = 1'b0;
         held_valid_in = 1'b0;
         held_byte_in  = '0;
         emitted_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surrogate_mode_ff <= 1'b0;
         max_chars_ff      <= MAX_CHARS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SURROGATE_MODE: surrogate_mode_ff <= csr_data[0];
            REG_MAX_CHARS:      max_chars_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff    <= 1'b0;
         high_half_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         emitted_ff    <= '0;
      end else if (accept) begin
         stopped_ff    <= stopped_in;
         high_half_ff  <= high_half_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         emitted_ff    <= emitted_in;
      end
   end

   u2lcd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (accept ? n_res : 2'd0),
      .push_data (res),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (q_count)
   );

   assign rsp_valid      = not_empty;
   assign rsp_char_byte  = head.char_byte;
   assign rsp_last_byte  = head.last_byte;
   assign rsp_char_count = head.char_count;

   // The result queue never holds more items than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // A closing item always leaves at least the terminator to deliver.
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_text |=> rsp_valid)
      else $error("end of text produced no result");

   // A stopped string never keeps a pending high surrogate.
   a_stop_clears_high: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !high_half_ff)
      else $error("high surrogate pending after stop");

   // Nothing is held or counted right after a string has been closed.
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_text |=> !held_valid_ff && (emitted_ff == '0))
      else $error("string state not cleared at end of text");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import u2lcd_pkg::*;

   // The run is abandoned once this many clock cycles have passed. It is set above
   // the slowest correct run (every item causing three results, each waiting out
   // the longest receiver stall run, plus sender gaps and the settling pauses).
   localparam int CYCLE_LIMIT = 300000;

   // Cycles allowed after the last expected result before a register write,
   // and again before the final verdict, so the block can finish any item that
   // produced no result of its own.
   localparam int SETTLE_CYCLES = 10;

   // Code points the stimulus and the predictor need beyond the package.
   localparam int unsigned CP_LOWER_X   = 'h000078;
   localparam int unsigned CP_LOW_FIRST = 'h00DC00;
   localparam int unsigned CP_LOW_LAST  = 'h00DFFF;
   localparam int unsigned CP_SUPP_BASE = 'h010000;
   localparam int unsigned CP_MAX       = 'h1FFFFF;

   // Package code points at the width of the predictor's arithmetic.
   localparam int unsigned MACRON_CP     = 32'(CP_MACRON);
   localparam int unsigned BACKSLASH_CP  = 32'(CP_BACKSLASH);
   localparam int unsigned TILDE_CP      = 32'(CP_TILDE);
   localparam int unsigned HIGH_FIRST_CP = 32'(CP_HIGH_FIRST);
   localparam int unsigned HIGH_LAST_CP  = 32'(CP_HIGH_LAST);
   localparam int unsigned KANA_SHIFT    = 32'(KANA_OFFSET);

   typedef enum int {PACE_STEADY, PACE_BURSTS} pace_style_type;
   typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_style_type;

   // One code unit waiting to be offered to the block. When flush_first is
   // set, the sender holds it back until every expected byte has been seen.
   typedef struct {
      logic [CODE_W-1:0] code;
      bit                eot;
      bit                flush_first;
   } text_unit_type;

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CODE_W-1:0]      req_code_unit = '0;
   logic                   req_end_of_text = 1'b0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_char_byte;
   logic                   rsp_last_byte;
   logic [COUNT_W-1:0]     rsp_char_count;

   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_data;

   unicode_to_lcd_charset dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_byte   (rsp_char_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_char_count  (rsp_char_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   // Units still to be offered, and the ROM bytes the block owes us, oldest
   // first.
   text_unit_type text_units[$];
   rsp_type       lcd_bytes_due[$];

   int              mismatches = 0;
   int              cycles = 0;
   int              units_queued = 0;
   bit              flush_next = 0;
   bit              unit_taken = 0;
   pace_style_type  pace_style = PACE_BURSTS;
   stall_style_type stall_style = STALL_NONE;

   // Shadow of the configuration registers, updated as each write lands.
   bit                 cfg_surrogate = 0;
   logic [COUNT_W-1:0] cfg_max_chars = MAX_CHARS_RESET;

   // Shadow of the per-string conversion state.
   bit                held_ok = 0;
   logic [BYTE_W-1:0] held_rom = '0;
   int                chars_out = 0;
   bit                high_pending = 0;
   int unsigned       high_bits = 0;
   bit                text_stopped = 0;

   // Code points that the ROM lookup maps to something other than the block
   // character; used to steer random text toward the lookup.
   int unsigned symbol_points [30] = '{
      'h00A5, 'h2192, 'h2190, 'h00B0, 'h03B1, 'h00C4, 'h00E4, 'h00DF, 'h03B5, 'h00B5,
      'h03BC, 'h03C2, 'h03C1, 'h221A, 'h00B9, 'h00A4, 'h00A2, 'h2C60, 'h00F1, 'h00D6,
      'h00F6, 'h03F4, 'h221E, 'h03A9, 'h00DC, 'h00FC, 'h03A3, 'h03C0, 'h0304, 'h00F7
   };

   // ROM byte for one code point on the A00 character set.
   function automatic logic [BYTE_W-1:0] rom_byte_of(input int unsigned cp);
      logic [BYTE_W-1:0] rom;
      int unsigned       shifted;
      shifted = cp - KANA_SHIFT;
      rom = ROM_BLOCK;
      if (cp >= 'h20 && cp <= 'h7E) begin
         if (cp == BACKSLASH_CP) begin
            rom = ROM_YEN;
         end else if (cp == TILDE_CP) begin
            rom = ROM_DASH;
         end else begin
            rom = cp[BYTE_W-1:0];
         end
      end else if (cp >= 'hFF61 && cp <= 'hFF9F) begin
         // Halfwidth katakana lands directly in the ROM's kana rows.
         rom = shifted[BYTE_W-1:0];
      end else begin
         case (cp)
            'h00A5: rom = 8'h5C;
            'h2192: rom = 8'h7E;
            'h2190: rom = 8'h7F;
            'h00B0: rom = 8'hDF;
            'h03B1: rom = 8'hE0;
            'h00C4, 'h00E4: rom = 8'hE1;
            'h00DF: rom = 8'hE2;
            'h03B5: rom = 8'hE3;
            'h00B5, 'h03BC: rom = 8'hE4;
            'h03C2: rom = 8'hE5;
            'h03C1: rom = 8'hE6;
            'h221A: rom = 8'hE8;
            'h00B9: rom = 8'hE9;
            'h00A4: rom = 8'hEB;
            'h00A2: rom = 8'hEC;
            'h2C60: rom = 8'hED;
            'h00F1: rom = 8'hEE;
            'h00D6, 'h00F6: rom = 8'hEF;
            'h03F4: rom = 8'hF2;
            'h221E: rom = 8'hF3;
            'h03A9: rom = 8'hF4;
            'h00DC, 'h00FC: rom = 8'hF5;
            'h03A3: rom = 8'hF6;
            'h03C0: rom = 8'hF7;
            'h0304: rom = 8'hF8;
            'h00F7: rom = 8'hFD;
            default: rom = ROM_BLOCK;
         endcase
      end
      return rom;
   endfunction

   task automatic owe_byte(input logic [BYTE_W-1:0] rom, input bit closing);
      rsp_type due;
      due.char_byte  = rom;
      due.last_byte  = closing;
      due.char_count = chars_out[COUNT_W-1:0];
      lcd_bytes_due.push_back(due);
   endtask

   // Advances the shadow conversion state by one accepted unit and records
   // every ROM byte that the unit releases.
   task automatic convert_unit(input int unsigned cu, input bit eot);
      bit          have_char;
      int unsigned cp;
      logic [BYTE_W-1:0] rom;
      have_char = 0;
      cp = 0;
      rom = ROM_BLOCK;
      if (!text_stopped) begin
         if (cu == 0) begin
            // A zero unit ends conversion; a pending high half is lost, but
            // the held character waits for the end of text.
            text_stopped = 1;
            high_pending = 0;
         end else begin
            if (high_pending) begin
               // The unit after a high half always forms one character.
               high_pending = 0;
               have_char = 1;
               if (cu >= CP_LOW_FIRST && cu <= CP_LOW_LAST) begin
                  cp = CP_SUPP_BASE + (high_bits << 10) + (cu - CP_LOW_FIRST);
                  rom = rom_byte_of(cp);
               end else begin
                  cp = CP_SUPP_BASE;
               end
            end else if (cfg_surrogate && cu >= HIGH_FIRST_CP && cu <= HIGH_LAST_CP) begin
               high_bits = (cu - HIGH_FIRST_CP) & 'h3FF;
               high_pending = 1;
            end else begin
               cp = cu;
               rom = rom_byte_of(cp);
               have_char = 1;
            end
            // Characters, the macron included, are dropped once the string
            // is at capacity.
            if (have_char && chars_out + (held_ok ? 1 : 0) < int'(cfg_max_chars)) begin
               if (cp == MACRON_CP) begin
                  if (held_ok) begin
                     held_rom = (held_rom == ROM_LOWER_X) ? ROM_X_BAR : ROM_BLOCK;
                  end else begin
                     held_rom = ROM_BLOCK;
                     held_ok = 1;
                  end
               end else begin
                  if (held_ok) begin
                     chars_out++;
                     owe_byte(held_rom, 0);
                  end
                  held_rom = rom;
                  held_ok = 1;
               end
            end
         end
      end
      if (eot) begin
         if (held_ok) begin
            chars_out++;
            owe_byte(held_rom, 0);
         end
         owe_byte(ROM_NUL, 1);
         held_ok = 0;
         held_rom = '0;
         chars_out = 0;
         high_pending = 0;
         high_bits = 0;
         text_stopped = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= 100) begin
         $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   // Input side: offer the next unit at the falling edge. A unit stays on the
   // pins until the rising edge that takes it. In burst mode the sender runs
   // for a random number of units and then pauses for a random gap.
   int gap_left = 0;
   int burst_left = 1;
   text_unit_type next_unit;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (unit_taken || !req_valid) begin
         unit_taken = 0;
         if (text_units.size() != 0 && gap_left == 0 &&
             !(text_units[0].flush_first && lcd_bytes_due.size() != 0)) begin
            next_unit = text_units.pop_front();
            req_valid       <= 1'b1;
            req_code_unit   <= next_unit.code;
            req_end_of_text <= next_unit.eot;
            if (pace_style == PACE_BURSTS) begin
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left = $urandom_range(1, 8);
                  burst_left = $urandom_range(1, 24);
               end
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end
         end
      end
   end

   // Output side: the receiver's stall follows its own pattern, either never,
   // on randomly scattered cycles, or in runs of stalled and open cycles.
   int stall_run = 0;
   bit stall_on = 0;

   always @(negedge clock) begin
      if (reset || stall_style == STALL_NONE) begin
         rsp_stall <= 1'b0;
      end else if (stall_style == STALL_SCATTER) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         if (stall_run == 0) begin
            stall_on = ($urandom_range(0, 2) == 0);
            stall_run = $urandom_range(1, 10);
         end
         stall_run--;
         rsp_stall <= stall_on;
      end
   end

   // Monitor: every rising edge first checks a delivered byte against the
   // oldest one owed, then predicts the bytes of a unit taken at this edge.
   // Both happen in one block so the bookkeeping does not depend on the order
   // in which processes run.
   rsp_type due_now;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (lcd_bytes_due.size() == 0) begin
               report_mismatch("byte with none owed", 32'(rsp_char_byte), 0);
            end else begin
               due_now = lcd_bytes_due.pop_front();
               if (rsp_char_byte !== due_now.char_byte) begin
                  report_mismatch("char_byte", 32'(rsp_char_byte),
                                  32'(due_now.char_byte));
               end
               if (rsp_last_byte !== due_now.last_byte) begin
                  report_mismatch("last_byte", 32'(rsp_last_byte),
                                  32'(due_now.last_byte));
               end
               if (rsp_char_count !== due_now.char_count) begin
                  report_mismatch("char_count", 32'(rsp_char_count),
                                  32'(due_now.char_count));
               end
            end
         end
         if (req_valid && !req_stall) begin
            convert_unit(32'(req_code_unit), req_end_of_text);
            unit_taken = 1;
         end
      end
   end

   task automatic add_unit(input int unsigned code, input bit eot);
      text_unit_type u;
      u.code = CODE_W'(code);
      u.eot = eot;
      u.flush_first = flush_next;
      flush_next = 0;
      text_units.push_back(u);
      units_queued++;
   endtask

   // One random character; a surrogate pair takes two units, with the end of
   // text flag on the low half.
   task automatic add_random_char(input bit last);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         add_unit($urandom_range('h20, 'h7E), last);
      end else if (pick < 46) begin
         add_unit(CP_LOWER_X, last);
      end else if (pick < 54) begin
         add_unit(MACRON_CP, last);
      end else if (pick < 58) begin
         add_unit($urandom_range(0, 1) ? BACKSLASH_CP : TILDE_CP, last);
      end else if (pick < 64) begin
         add_unit($urandom_range('hFF5E, 'hFFA2), last);
      end else if (pick < 72) begin
         add_unit(symbol_points[$urandom_range(0, 29)], last);
      end else if (pick < 78) begin
         add_unit($urandom_range(HIGH_FIRST_CP, HIGH_LAST_CP), 0);
         add_unit($urandom_range(CP_LOW_FIRST, CP_LOW_LAST), last);
      end else if (pick < 81) begin
         add_unit($urandom_range(HIGH_FIRST_CP, HIGH_LAST_CP), last);
      end else if (pick < 84) begin
         add_unit($urandom_range(CP_LOW_FIRST, CP_LOW_LAST), last);
      end else if (pick < 86) begin
         add_unit(0, last);
      end else if (pick < 93) begin
         add_unit($urandom_range(1, 'hFFFF), last);
      end else begin
         add_unit($urandom_range(1, CP_MAX), last);
      end
   endtask

   task automatic add_string(input int len);
      if ($urandom_range(0, 19) == 0) begin
         flush_next = 1;
      end
      for (int i = 0; i < len; i++) begin
         add_random_char(i == len - 1);
      end
   endtask

   // Waits until every queued unit has been taken and every owed byte has
   // arrived, then waits out SETTLE_CYCLES. Checked just after the rising edge, when
   // the monitor and the sender have both settled.
   task automatic wait_idle();
      bit idle;
      idle = 0;
      while (!idle) begin
         @(posedge clock);
         #1;
         idle = text_units.size() == 0 && (!req_valid || unit_taken) &&
                lcd_bytes_due.size() == 0;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_SURROGATE_MODE) begin
         cfg_surrogate = val[0];
      end else begin
         cfg_max_chars = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input bit surrogate, input logic [COUNT_W-1:0] max_chars);
      wait_idle();
      write_csr(REG_SURROGATE_MODE, COUNT_W'(surrogate));
      write_csr(REG_MAX_CHARS, max_chars);
      #1;
   endtask

   initial begin
      int phase_start;
      int len;
      logic [COUNT_W-1:0] max_pick;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = REG_SURROGATE_MODE;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed text at the reset configuration: macron cases, the ASCII
      // swaps, the kana window edges, lookup symbols, surrogates outside
      // surrogate mode, the widest code unit, and a zero unit mid-string.
      @(posedge clock);
      #1;
      stall_style = STALL_RUNS;
      add_unit(MACRON_CP, 0);
      add_unit(CP_LOWER_X, 0);
      add_unit(MACRON_CP, 0);
      add_unit('h41, 0);
      add_unit(MACRON_CP, 0);
      add_unit(BACKSLASH_CP, 0);
      add_unit(TILDE_CP, 0);
      add_unit('h20, 0);
      add_unit('h7F, 0);
      add_unit('h1F, 0);
      add_unit('hFF61, 0);
      add_unit('hFF9F, 0);
      add_unit('hFF60, 0);
      add_unit('hFFA0, 0);
      add_unit('hB0, 0);
      add_unit('h2192, 0);
      add_unit('h3C0, 0);
      add_unit(HIGH_FIRST_CP, 0);
      add_unit(CP_MAX, 0);
      add_unit('h10FFFF, 1);
      // The sender holds this one until the whole string above has come out.
      flush_next = 1;
      add_unit('h41, 0);
      add_unit(0, 0);
      add_unit('h42, 0);
      add_unit(0, 1);
      add_unit(CP_LOWER_X, 1);

      // Surrogate mode: proper pairs at both ends of the ranges, a high half
      // followed by a plain character or by another high half, a lone low
      // half, a unit above the 16-bit range, a high half cut off by a zero
      // unit, and one cut off by the end of text.
      configure(1'b1, MAX_CHARS_RESET);
      stall_style = STALL_SCATTER;
      add_unit(HIGH_FIRST_CP, 0);
      add_unit(CP_LOW_FIRST, 0);
      add_unit(HIGH_LAST_CP, 0);
      add_unit(CP_LOW_LAST, 0);
      add_unit('hD83D, 0);
      add_unit('h41, 0);
      add_unit(CP_LOW_FIRST, 0);
      add_unit(CP_SUPP_BASE, 0);
      add_unit(HIGH_FIRST_CP, 0);
      add_unit(HIGH_FIRST_CP, 0);
      add_unit('hD801, 0);
      add_unit(0, 0);
      add_unit('h43, 1);
      add_unit(HIGH_FIRST_CP, 1);
      add_unit(MACRON_CP, 1);

      // Capacity of one character: the macron on a full string is dropped.
      configure(1'b0, 8'd1);
      add_unit(CP_LOWER_X, 0);
      add_unit(MACRON_CP, 0);
      add_unit('h42, 1);
      add_unit('h61, 0);
      add_unit('h62, 1);

      // No capacity at all: only the terminator comes out.
      configure(1'b1, 8'd0);
      add_unit('h41, 0);
      add_unit(CP_LOWER_X, 1);
      add_unit(MACRON_CP, 1);

      // Largest capacity with a string that overruns it, so the count
      // reaches its top value. No idling on either side here.
      configure(1'b0, 8'd255);
      pace_style = PACE_STEADY;
      stall_style = STALL_NONE;
      for (int i = 0; i < 270; i++) begin
         add_unit($urandom_range('h20, 'h7E), i == 269);
      end

      // Random phases: mostly well-formed strings with random content, under
      // random configurations and random idling on both sides.
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 4))
            0: max_pick = 8'd1;
            1: max_pick = COUNT_W'($urandom_range(2, 5));
            2: max_pick = MAX_CHARS_RESET;
            3: max_pick = 8'd255;
            default: max_pick = COUNT_W'($urandom_range(1, 255));
         endcase
         configure(1'($urandom_range(0, 1)), max_pick);
         pace_style = pace_style_type'($urandom_range(0, 1));
         stall_style = stall_style_type'($urandom_range(0, 2));
         phase_start = units_queued;
         while (units_queued - phase_start < 8) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            add_string(len);
         end
      end

      // Let everything drain, then give the verdict.
      wait_idle();
      if (lcd_bytes_due.size() != 0) begin
         report_mismatch("bytes never delivered", 0, lcd_bytes_due.size());
      end
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/u2lcd_pkg.sv
hdl/u2lcd_queue.sv
hdl/unicode_to_lcd_charset.sv
tb/sv/testbench.sv
